>>> rtl/core/cfir_pkg.sv
// ----------------------------------------------------------------------------
// cfir_pkg - shared definitions for the complex FIR filter
// Operation codes, control state encoding, register map and fixed field widths.
// ----------------------------------------------------------------------------
package cfir_pkg;

	// Fixed widths of the item fields and of the register port.
	localparam int TAP_INDEX_W = 6;
	localparam int TAP_COUNT_W = 7;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_TAP_COUNT = 1'b0;

	typedef enum logic [1:0] {
		OP_FILTER   = 2'd0,
		OP_LOAD_TAP = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Control that travels alongside each tap read through the datapath.
	typedef struct packed {
		logic vld;
		logic live;
		logic last;
	} tap_ctl_t;

endpackage

>>> rtl/core/cfir_ram.sv
// ----------------------------------------------------------------------------
// cfir_ram - simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/complex_fir_filter.sv
// ----------------------------------------------------------------------------
// complex_fir_filter - complex-tap FIR filter on I/Q samples
// Memory based filter: one complex multiply-accumulate per tap per cycle,
// with coefficients and sample history held in two synchronous RAMs.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                        | beat contents
//   ---------+----------------------------------+------------------------------
//   item     | item_valid / item_stall          | operation, sample_re/_im,
//            |                                  | tap_index, tap_re/_im
//   result   | result_valid / result_stall      | out_re, out_im, clipped
//   config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A filter beat (effective tap count n, 1..MAX_TAPS) goes through these steps:
// accept and write the sample, n tap reads from the two RAM read ports, the
// RAM read data and product registers, and rounding into the result
// register. The single multiply-accumulate datapath, fed one tap per
// cycle, sets the pace, and no new item is taken before the beat is done.
// Load-tap and clear beats produce no result.
// After reset the coefficient RAM is initialized by a sweep over all MAX_TAPS
// addresses, during which item_stall is high; register writes are taken throughout.
// A stalled result holds in its output register while the next item is
// accepted and computed; that item then waits only at its final rounding step.
// ----------------------------------------------------------------------------
module complex_fir_filter #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// Item channel
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic [1:0]                            operation,
	input  logic signed [SAMPLE_BITS-1:0]         sample_re,
	input  logic signed [SAMPLE_BITS-1:0]         sample_im,
	input  logic [cfir_pkg::TAP_INDEX_W-1:0]      tap_index,
	input  logic signed [COEF_BITS-1:0]           tap_re,
	input  logic signed [COEF_BITS-1:0]           tap_im,

	// Result channel
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [SAMPLE_BITS-1:0]         out_re,
	output logic signed [SAMPLE_BITS-1:0]         out_im,
	output logic                                  clipped,

	// Register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [cfir_pkg::PADDR_W-1:0]          paddr,
	input  logic [cfir_pkg::PDATA_W-1:0]          pwdata,
	output logic [cfir_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);

	// Address width of both RAMs and width of a tap count (0..MAX_TAPS).
	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW = $clog2(MAX_TAPS + 1);

	// Each product is exact; a tap adds two of them, and up to MAX_TAPS taps
	// are summed, so the accumulator grows by one bit plus the count width.
	localparam int PW    = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W = PW + 1 + CW;
	localparam int SHIFT = COEF_BITS - 2;

	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
	localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_TAPS);

	localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(2 ** (COEF_BITS - 2));
	localparam logic signed [ACC_W-1:0]     RND_HALF  = ACC_W'(2 ** (SHIFT - 1));
	localparam logic signed [ACC_W-1:0]     OUT_MAX   = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [ACC_W-1:0]     OUT_MIN   = ~OUT_MAX;

	// Effective tap count: zero counts as one, large values clamp to the depth.
	function automatic logic [CW-1:0] eff_taps(input logic [cfir_pkg::TAP_COUNT_W-1:0] v);
		logic [CW-1:0] r;
		if (v == '0) begin
			r = CW'(1);
		end else if (32'(v) > MAX_TAPS) begin
			r = CNT_MAX;
		end else begin
			r = CW'(v);
		end
		return r;
	endfunction

	cfir_pkg::state_t state_q, state_d;

	// Configuration and ring bookkeeping.
	logic [cfir_pkg::TAP_COUNT_W-1:0] tap_count_q;
	logic [AW-1:0]                    ptr_q;
	logic [AW-1:0]                    ptr_next;
	logic [CW-1:0]                    fill_q;
	logic                             cfg_wr;
	logic                             cfg_sel;
	logic                             cfg_change;

	// Tap sequencer.
	logic [AW-1:0] sw_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] n_q;
	logic          last_issue;

	// Decoded item beats.
	logic item_take;
	logic take_filter;
	logic take_load;
	logic take_clear;
	logic tap_in_range;

	// RAM ports.
	logic                       coef_we;
	logic [AW-1:0]              coef_waddr;
	logic [2*COEF_BITS-1:0]     coef_wdata;
	logic [2*COEF_BITS-1:0]     coef_rdata;
	logic                       hist_we;
	logic [2*SAMPLE_BITS-1:0]   hist_rdata;

	// Datapath.
	cfir_pkg::tap_ctl_t ctl_s1, ctl_s2;
	logic signed [SAMPLE_BITS-1:0] xr_s1, xi_s1;
	logic signed [COEF_BITS-1:0]   hr_s1, hi_s1;
	logic signed [PW-1:0]          rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [ACC_W-1:0]       acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0]       sum_re, sum_im;
	logic signed [ACC_W-1:0]       shr_re, shr_im;
	logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
	logic                          clip_re, clip_im;

	// Result register.
	logic                          out_valid_q;
	logic                          out_load;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] out_re_q, out_im_q;
	logic                          clipped_q;

	// ------------------------------------------------------------------------
	// Register port. pready is tied high, so every access completes in its
	// access phase. Only the word address bit selects the register.
	// ------------------------------------------------------------------------
	assign pready     = 1'b1;
	assign cfg_sel    = (paddr[2] == cfir_pkg::REG_TAP_COUNT);
	assign cfg_wr     = psel && penable && pwrite && cfg_sel;
	assign cfg_change = cfg_wr
		&& (eff_taps(pwdata[cfir_pkg::TAP_COUNT_W-1:0]) != eff_taps(tap_count_q));
	assign prdata     = cfg_sel ? cfir_pkg::PDATA_W'(tap_count_q) : '0;

	// ------------------------------------------------------------------------
	// Item decode and ring pointer arithmetic.
	// ------------------------------------------------------------------------
	assign item_stall   = (state_q != cfir_pkg::ST_IDLE);
	assign item_take    = item_valid && !item_stall;
	assign take_filter  = item_take && (operation == cfir_pkg::OP_FILTER);
	assign take_load    = item_take && (operation == cfir_pkg::OP_LOAD_TAP);
	assign take_clear   = item_take && (operation == cfir_pkg::OP_CLEAR);
	assign tap_in_range = (32'(tap_index) < MAX_TAPS);

	assign ptr_next   = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
	assign last_issue = (CW'(k_q) + CW'(1)) == n_q;
	assign out_free   = !out_valid_q || !result_stall;

	// ------------------------------------------------------------------------
	// Control state machine and RAM write port selection.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfir_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		coef_we    = 1'b0;
		coef_waddr = AW'(tap_index);
		coef_wdata = {tap_re, tap_im};
		hist_we    = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			cfir_pkg::ST_INIT: begin
				// Coefficient store comes up as a single unity tap.
				coef_we    = 1'b1;
				coef_waddr = sw_q;
				coef_wdata = (sw_q == '0) ? {COEF_ONE, {COEF_BITS{1'b0}}} : '0;
				if (sw_q == LAST_ADDR) begin
					state_d = cfir_pkg::ST_IDLE;
				end
			end
			cfir_pkg::ST_IDLE: begin
				if (take_filter) begin
					hist_we = 1'b1;
					state_d = cfir_pkg::ST_ISSUE;
				end
				if (take_load && tap_in_range) begin
					coef_we = 1'b1;
				end
			end
			cfir_pkg::ST_ISSUE: begin
				if (last_issue) begin
					state_d = cfir_pkg::ST_DRAIN;
				end
			end
			cfir_pkg::ST_DRAIN: begin
				// The last product is added at this edge.
				if (ctl_s2.vld && ctl_s2.last) begin
					state_d = cfir_pkg::ST_FINISH;
				end
			end
			cfir_pkg::ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = cfir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cfir_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Ring state, tap sequencer and pipeline control.
	// The history ring is never cleared in memory: fill_q counts the samples
	// written since the last clear, and a tap that reaches further back than
	// that reads as zero.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= cfir_pkg::TAP_COUNT_W'(1);
			ptr_q       <= '0;
			fill_q      <= '0;
			sw_q        <= '0;
			k_q         <= '0;
			rp_q        <= '0;
			n_q         <= CW'(1);
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				tap_count_q <= pwdata[cfir_pkg::TAP_COUNT_W-1:0];
			end

			if (cfg_change || take_clear) begin
				ptr_q  <= '0;
				fill_q <= '0;
			end else if (take_filter) begin
				ptr_q  <= ptr_next;
				fill_q <= (fill_q == CNT_MAX) ? CNT_MAX : fill_q + 1'b1;
			end

			if (state_q == cfir_pkg::ST_INIT) begin
				sw_q <= sw_q + 1'b1;
			end

			if (take_filter) begin
				k_q  <= '0;
				rp_q <= ptr_next;
				n_q  <= eff_taps(tap_count_q);
			end else if (state_q == cfir_pkg::ST_ISSUE) begin
				k_q  <= k_q + 1'b1;
				rp_q <= (rp_q == '0) ? LAST_ADDR : rp_q - 1'b1;
			end

			ctl_s1.vld  <= (state_q == cfir_pkg::ST_ISSUE);
			ctl_s1.live <= (CW'(k_q) < fill_q);
			ctl_s1.last <= last_issue;
			ctl_s2      <= ctl_s1;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Memories. Coefficient k and the sample k steps back are read together.
	// ------------------------------------------------------------------------
	cfir_ram #(
		.WIDTH (2 * COEF_BITS),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (k_q),
		.rdata (coef_rdata)
	);

	cfir_ram #(
		.WIDTH (2 * SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (ptr_next),
		.wdata ({sample_re, sample_im}),
		.raddr (rp_q),
		.rdata (hist_rdata)
	);

	// ------------------------------------------------------------------------
	// Multiply-accumulate datapath.
	// Stage 1 is the RAM read data; history beyond the fill level is zeroed.
	// Stage 2 holds the four partial products; the accumulators follow.
	// ------------------------------------------------------------------------
	assign xr_s1 = ctl_s1.live ? $signed(hist_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
	assign xi_s1 = ctl_s1.live ? $signed(hist_rdata[SAMPLE_BITS-1:0]) : '0;
	assign hr_s1 = $signed(coef_rdata[2*COEF_BITS-1:COEF_BITS]);
	assign hi_s1 = $signed(coef_rdata[COEF_BITS-1:0]);

	always_ff @(posedge clk) begin
		rr_s2 <= xr_s1 * hr_s1;
		ii_s2 <= xi_s1 * hi_s1;
		ri_s2 <= xr_s1 * hi_s1;
		ir_s2 <= xi_s1 * hr_s1;

		if (take_filter) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (ctl_s2.vld) begin
			acc_re_q <= acc_re_q + ACC_W'(rr_s2) - ACC_W'(ii_s2);
			acc_im_q <= acc_im_q + ACC_W'(ri_s2) + ACC_W'(ir_s2);
		end

		if (out_load) begin
			out_re_q  <= sat_re;
			out_im_q  <= sat_im;
			clipped_q <= clip_re || clip_im;
		end
	end

	// Round half up to the sample format, then saturate.
	always_comb begin
		sum_re  = acc_re_q + RND_HALF;
		sum_im  = acc_im_q + RND_HALF;
		shr_re  = sum_re >>> SHIFT;
		shr_im  = sum_im >>> SHIFT;
		clip_re = (shr_re > OUT_MAX) || (shr_re < OUT_MIN);
		clip_im = (shr_im > OUT_MAX) || (shr_im < OUT_MIN);
		if (shr_re > OUT_MAX) begin
			sat_re = OUT_MAX[SAMPLE_BITS-1:0];
		end else if (shr_re < OUT_MIN) begin
			sat_re = OUT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat_re = shr_re[SAMPLE_BITS-1:0];
		end
		if (shr_im > OUT_MAX) begin
			sat_im = OUT_MAX[SAMPLE_BITS-1:0];
		end else if (shr_im < OUT_MIN) begin
			sat_im = OUT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat_im = shr_im[SAMPLE_BITS-1:0];
		end
	end

	assign result_valid = out_valid_q;
	assign out_re       = out_re_q;
	assign out_im       = out_im_q;
	assign clipped      = clipped_q;

endmodule

>>> tb/tb_complex_fir_filter.sv
// ----------------------------------------------------------------------------
// tb_complex_fir_filter - self-checking testbench for the complex FIR filter
// Drives item beats and tap_count register writes, predicts every filter
// output with a bit-exact fixed-point model of its own, and compares each
// result beat field by field against the oldest expected output.
// ----------------------------------------------------------------------------
module tb_complex_fir_filter;

	localparam int MAX_TAPS    = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;

	// Operation code 3 is not decoded by the block; it must be dropped silently.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [cfir_pkg::PADDR_W-1:0] TAP_COUNT_ADDR = {cfir_pkg::REG_TAP_COUNT, 2'b00};

	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
	localparam longint ROUND_HALF = 64'sd1 <<< (COEF_BITS - 3);

	// DRAIN_CYCLES outlasts any filter beat, so this pause covers any beat
	// still in flight once the last expected output has arrived.
	localparam int DRAIN_CYCLES   = MAX_TAPS + 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PERCENT   = 32;
	localparam int NUM_PHASES     = 10;
	localparam int CALM_PHASE     = 2;
	localparam int HOLD_PHASE     = 5;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          clip;
	} filter_out_t;

	// One row of the directed table: either a register write or an item beat,
	// the latter optionally with an output that is known by inspection.
	typedef struct packed {
		bit                                bit_is_cfg_unused_guard;
		bit                                is_cfg;
		logic [cfir_pkg::TAP_COUNT_W-1:0]  cfg_value;
		logic [1:0]                        op;
		logic [SAMPLE_BITS-1:0]            s_re;
		logic [SAMPLE_BITS-1:0]            s_im;
		logic [cfir_pkg::TAP_INDEX_W-1:0]  idx;
		logic [COEF_BITS-1:0]              t_re;
		logic [COEF_BITS-1:0]              t_im;
		bit                                known;
		filter_out_t                       want;
	} stim_row_t;

	logic                             clk;
	logic                             arst_n       = 1'b0;
	logic                             item_valid   = 1'b0;
	logic                             item_stall;
	logic [1:0]                       operation    = '0;
	logic signed [SAMPLE_BITS-1:0]    sample_re    = '0;
	logic signed [SAMPLE_BITS-1:0]    sample_im    = '0;
	logic [cfir_pkg::TAP_INDEX_W-1:0] tap_index    = '0;
	logic signed [COEF_BITS-1:0]      tap_re       = '0;
	logic signed [COEF_BITS-1:0]      tap_im       = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0]    out_re;
	logic signed [SAMPLE_BITS-1:0]    out_im;
	logic                             clipped;
	logic                             psel         = 1'b0;
	logic                             penable      = 1'b0;
	logic                             pwrite       = 1'b0;
	logic [cfir_pkg::PADDR_W-1:0]     paddr        = '0;
	logic [cfir_pkg::PDATA_W-1:0]     pwdata       = '0;
	logic [cfir_pkg::PDATA_W-1:0]     prdata;
	logic                             pready;

	// The stimulus process owns phase_num; both sides stop idling in the calm
	// phase, and the receiver starts its long hold-off in the hold phase.
	int  phase_num = -1;
	int  errors    = 0;
	wire calm      = (phase_num == CALM_PHASE);

	filter_out_t pending_outputs[$];
	stim_row_t   directed_rows[$];

	// Shadow of the block's state, kept in step with every accepted beat.
	logic signed [COEF_BITS-1:0]      tap_re_store [MAX_TAPS];
	logic signed [COEF_BITS-1:0]      tap_im_store [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]    hist_re_ring [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]    hist_im_ring [MAX_TAPS];
	logic [cfir_pkg::TAP_INDEX_W-1:0] newest_slot;
	logic [cfir_pkg::TAP_COUNT_W-1:0] tap_count_shadow;

	complex_fir_filter #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.tap_index    (tap_index),
		.tap_re       (tap_re),
		.tap_im       (tap_im),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_re       (out_re),
		.out_im       (out_im),
		.clipped      (clipped),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Output predictor
	// ------------------------------------------------------------------------

	// A register value of zero behaves as one tap, anything above the tap
	// store depth behaves as the full depth.
	function automatic int unsigned active_taps(logic [cfir_pkg::TAP_COUNT_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_TAPS)
			return MAX_TAPS;
		return 32'(v);
	endfunction

	function void clear_history();
		foreach (hist_re_ring[i]) begin
			hist_re_ring[i] = '0;
			hist_im_ring[i] = '0;
		end
		newest_slot = '0;
	endfunction

	function void reset_shadow();
		foreach (tap_re_store[i]) begin
			tap_re_store[i] = '0;
			tap_im_store[i] = '0;
		end
		tap_re_store[0]  = COEF_BITS'(1 << (COEF_BITS - 2));
		tap_count_shadow = cfir_pkg::TAP_COUNT_W'(1);
		clear_history();
	endfunction

	// Only a change of the effective tap count flushes the history; writing
	// a different value that maps to the same count leaves it in place.
	function void set_tap_count(logic [cfir_pkg::TAP_COUNT_W-1:0] v);
		int unsigned old_n;
		old_n = active_taps(tap_count_shadow);
		tap_count_shadow = v;
		if (active_taps(v) != old_n)
			clear_history();
	endfunction

	// Drop the Q2.14 fraction with round half up, then clamp to Q1.15.
	function automatic logic signed [SAMPLE_BITS-1:0] round_q15(longint acc, output bit sat);
		longint r;
		r = (acc + ROUND_HALF) >>> (COEF_BITS - 2);
		sat = 1'b0;
		if (r > SAMPLE_MAX) begin
			sat = 1'b1;
			r = SAMPLE_MAX;
		end else if (r < SAMPLE_MIN) begin
			sat = 1'b1;
			r = SAMPLE_MIN;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	// Applies one accepted beat to the shadow state. Returns 1 with the
	// expected output when the beat is a filter sample.
	function automatic bit filter_response(
		logic [1:0]                       op,
		logic signed [SAMPLE_BITS-1:0]    sre,
		logic signed [SAMPLE_BITS-1:0]    sim,
		logic [cfir_pkg::TAP_INDEX_W-1:0] idx,
		logic signed [COEF_BITS-1:0]      tre,
		logic signed [COEF_BITS-1:0]      tim,
		output filter_out_t               y
	);
		longint                           acc_re;
		longint                           acc_im;
		longint                           xr, xi, hr, hi;
		logic [cfir_pkg::TAP_INDEX_W-1:0] slot;
		int unsigned                      n;
		bit                               sat_re, sat_im;
		y = '0;
		case (op)
			cfir_pkg::OP_LOAD_TAP: begin
				tap_re_store[idx] = tre;
				tap_im_store[idx] = tim;
				return 1'b0;
			end
			cfir_pkg::OP_CLEAR: begin
				clear_history();
				return 1'b0;
			end
			cfir_pkg::OP_FILTER: begin
				newest_slot = newest_slot + 1'b1;
				hist_re_ring[newest_slot] = sre;
				hist_im_ring[newest_slot] = sim;
				n = active_taps(tap_count_shadow);
				acc_re = 0;
				acc_im = 0;
				for (int k = 0; k < n; k++) begin
					slot = newest_slot - cfir_pkg::TAP_INDEX_W'(k);
					xr = longint'(hist_re_ring[slot]);
					xi = longint'(hist_im_ring[slot]);
					hr = longint'(tap_re_store[k]);
					hi = longint'(tap_im_store[k]);
					acc_re += xr * hr - xi * hi;
					acc_im += xr * hi + xi * hr;
				end
				y.re   = round_q15(acc_re, sat_re);
				y.im   = round_q15(acc_im, sat_im);
				y.clip = sat_re | sat_im;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------

	function void add_row_item(logic [1:0] op, logic [15:0] sre, logic [15:0] sim,
			logic [5:0] idx, logic [15:0] tre, logic [15:0] tim);
		stim_row_t r;
		r = '0;
		r.op   = op;
		r.s_re = sre;
		r.s_im = sim;
		r.idx  = idx;
		r.t_re = tre;
		r.t_im = tim;
		directed_rows.push_back(r);
	endfunction

	// Filter beat whose output is written down directly.
	function void add_row_known(logic [15:0] sre, logic [15:0] sim,
			logic [15:0] yre, logic [15:0] yim, logic yclip);
		stim_row_t r;
		r = '0;
		r.op    = cfir_pkg::OP_FILTER;
		r.s_re  = sre;
		r.s_im  = sim;
		r.known = 1'b1;
		r.want  = {yre, yim, yclip};
		directed_rows.push_back(r);
	endfunction

	function void add_row_cfg(logic [cfir_pkg::TAP_COUNT_W-1:0] v);
		stim_row_t r;
		r = '0;
		r.is_cfg    = 1'b1;
		r.cfg_value = v;
		directed_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// Random field values
	// ------------------------------------------------------------------------

	// Mostly uniform samples, with the corners of the range mixed in.
	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		logic [SAMPLE_BITS-1:0] v;
		v = SAMPLE_BITS'($urandom);
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: v = 16'h7fff;
				1: v = 16'h8000;
				2: v = 16'h0000;
				default: v = 16'hffff;
			endcase
		end
		return v;
	endfunction

	// Coefficients at a random scale, so that long filters do not clip on
	// every output while full-scale taps still show up.
	function automatic logic [COEF_BITS-1:0] random_tap();
		logic signed [COEF_BITS-1:0] v;
		v = COEF_BITS'($urandom);
		return v >>> $urandom_range(0, 7);
	endfunction

	// ------------------------------------------------------------------------
	// Item channel driver
	// ------------------------------------------------------------------------

	// Called just after a rising edge. Idles at random, then offers one beat
	// and holds it until accepted. It returns in the time step of the edge at
	// which the beat went in, leaving item_valid high for the next caller.
	task automatic send_item(logic [1:0] op, logic [15:0] sre, logic [15:0] sim,
			logic [5:0] idx, logic [15:0] tre, logic [15:0] tim,
			bit known, filter_out_t want);
		filter_out_t y;
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		sample_re  <= sre;
		sample_im  <= sim;
		tap_index  <= idx;
		tap_re     <= tre;
		tap_im     <= tim;
		do
			@(posedge clk);
		while (item_stall);
		if (filter_response(op, sre, sim, idx, tre, tim, y))
			pending_outputs.push_back(known ? want : y);
	endtask

	// Stop offering beats, wait for every expected output, then give any
	// load or clear beat still inside the block time to retire.
	task automatic drain_outputs();
		item_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup and access cycle of the register port. The upper data bits carry
	// junk that the 7-bit register must ignore.
	task automatic write_tap_count(logic [cfir_pkg::TAP_COUNT_W-1:0] v);
		logic [cfir_pkg::PDATA_W-1:0] w;
		w = $urandom;
		w[cfir_pkg::TAP_COUNT_W-1:0] = v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TAP_COUNT_ADDR;
		pwdata  <= w;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		set_tap_count(v);
	endtask

	// ------------------------------------------------------------------------
	// Result channel: random stall, with one long hold-off in the hold phase
	// so that the block backs up and stalls its item input.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (phase_num == HOLD_PHASE && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// Every accepted result beat is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		filter_out_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (pending_outputs.size() == 0) begin
				errors++;
				$display("%0t: result beat with no output expected, got re %0d im %0d clip %0b",
					$time, out_re, out_im, clipped);
			end else begin
				want = pending_outputs.pop_front();
				if (out_re !== want.re) begin
					errors++;
					$display("%0t: out_re expected %0d, got %0d", $time, $signed(want.re), out_re);
				end
				if (out_im !== want.im) begin
					errors++;
					$display("%0t: out_im expected %0d, got %0d", $time, $signed(want.im), out_im);
				end
				if (clipped !== want.clip) begin
					errors++;
					$display("%0t: clipped expected %0b, got %0b", $time, want.clip, clipped);
				end
			end
		end
	end

	// The run ends in failure if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_stall === 1'b0) ||
					(result_valid === 1'b1 && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog, no beat for %0d cycles, %0d outputs outstanding",
			$time, WATCHDOG_LIMIT, pending_outputs.size());
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		stim_row_t                        r;
		logic [cfir_pkg::TAP_COUNT_W-1:0] phase_taps [NUM_PHASES];
		int unsigned                      n;
		int                               quota;
		int                               count;
		int                               pick;
		logic [1:0]                       op;
		logic [cfir_pkg::TAP_INDEX_W-1:0] idx;

		reset_shadow();

		// After reset there is one unity tap, so a sample comes back as is.
		add_row_known(16'd1000, -16'sd2000, 16'd1000, -16'sd2000, 1'b0);
		add_row_known(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
		add_row_known(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
		// The unused operation must leave no trace, whatever its fields hold.
		add_row_item(OP_UNUSED, 16'd5, 16'd5, 6'd63, 16'h7fff, 16'h8000);
		// A tap of -2.0 drives full-scale inputs into saturation on both rails.
		add_row_item(cfir_pkg::OP_LOAD_TAP, 16'd0, 16'd0, 6'd0, 16'h8000, 16'd0);
		add_row_known(16'h7fff, 16'd0, 16'h8000, 16'd0, 1'b1);
		add_row_known(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b1);
		// A tap of +j rotates the sample by a quarter turn.
		add_row_item(cfir_pkg::OP_LOAD_TAP, 16'd0, 16'd0, 6'd0, 16'd0, 16'd16384);
		add_row_known(16'd100, 16'd200, -16'sd200, 16'd100, 1'b0);
		add_row_item(cfir_pkg::OP_LOAD_TAP, 16'd0, 16'd0, 6'd0, 16'd16384, 16'd0);
		add_row_item(cfir_pkg::OP_LOAD_TAP, 16'd0, 16'd0, 6'd63, 16'h7fff, 16'h8000);
		add_row_item(cfir_pkg::OP_LOAD_TAP, 16'd0, 16'd0, 6'd1, 16'd8192, -16'sd8192);
		add_row_item(cfir_pkg::OP_LOAD_TAP, 16'd0, 16'd0, 6'd2, -16'sd4096, 16'd2048);
		// Zero still means one tap, so the history survives this write.
		add_row_cfg(7'd0);
		add_row_item(cfir_pkg::OP_FILTER, 16'd12345, -16'sd321, 6'd0, 16'd0, 16'd0);
		// Going to the full depth flushes the history.
		add_row_cfg(7'd64);
		add_row_item(cfir_pkg::OP_FILTER, 16'd20000, 16'd10000, 6'd0, 16'd0, 16'd0);
		add_row_item(cfir_pkg::OP_FILTER, -16'sd15000, 16'd30000, 6'd0, 16'd0, 16'd0);
		add_row_item(cfir_pkg::OP_FILTER, 16'h7fff, 16'h7fff, 6'd0, 16'd0, 16'd0);
		add_row_item(cfir_pkg::OP_CLEAR, 16'd0, 16'd0, 6'd0, 16'd0, 16'd0);
		add_row_item(cfir_pkg::OP_FILTER, 16'd1234, 16'd5678, 6'd0, 16'd0, 16'd0);
		// Beyond the depth saturates to the same count, history kept.
		add_row_cfg(7'd127);
		add_row_item(cfir_pkg::OP_FILTER, 16'hffff, 16'h8000, 6'd0, 16'd0, 16'd0);
		add_row_cfg(7'd2);
		add_row_item(cfir_pkg::OP_FILTER, 16'd16000, -16'sd16000, 6'd0, 16'd0, 16'd0);
		add_row_item(cfir_pkg::OP_FILTER, -16'sd8000, 16'd4000, 6'd0, 16'd0, 16'd0);
		add_row_cfg(7'd2);
		add_row_item(cfir_pkg::OP_FILTER, 16'd300, -16'sd300, 6'd0, 16'd0, 16'd0);

		// Reset is applied once. The coefficient sweep that follows keeps
		// item_stall high, which the driver simply waits out.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.is_cfg) begin
				drain_outputs();
				write_tap_count(r.cfg_value);
			end else begin
				send_item(r.op, r.s_re, r.s_im, r.idx, r.t_re, r.t_im, r.known, r.want);
			end
		end

		// Random phases, each at its own tap count. Long filters get fewer
		// beats since every sample runs through the full tap count.
		phase_taps = '{7'd3, 7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd0, 7'd2, 7'd100, 7'd5};
		phase_taps[6] = cfir_pkg::TAP_COUNT_W'($urandom_range(1, 16));
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_outputs();
			write_tap_count(phase_taps[p]);
			phase_num = p;
			n = active_taps(phase_taps[p]);
			quota = (n > 16) ? 27 : 60;
			count = 0;
			while (count < quota) begin
				pick = $urandom_range(99);
				if (pick < 70)
					op = cfir_pkg::OP_FILTER;
				else if (pick < 88)
					op = cfir_pkg::OP_LOAD_TAP;
				else if (pick < 94)
					op = cfir_pkg::OP_CLEAR;
				else
					op = OP_UNUSED;
				// Most loads hit a tap that is in use right now.
				if ($urandom_range(9) < 7)
					idx = cfir_pkg::TAP_INDEX_W'($urandom_range(n - 1));
				else
					idx = cfir_pkg::TAP_INDEX_W'($urandom);
				send_item(op, random_sample(), random_sample(), idx,
					random_tap(), random_tap(), 1'b0, '0);
				if (op != OP_UNUSED)
					count++;
			end
		end

		phase_num = NUM_PHASES;
		drain_outputs();
		if (errors == 0 && pending_outputs.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
